// ===== src/coord_descent_update_accumulator_core_defines.svh =====
// assertion macros shared by the queue, multiplier and back-end files
`ifndef COORD_DESCENT_UPDATE_ACCUMULATOR_CORE_DEFINES_SVH
`define COORD_DESCENT_UPDATE_ACCUMULATOR_CORE_DEFINES_SVH

// condition must hold whenever the antecedent holds
`define CDUA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition must hold in the cycle after the antecedent
`define CDUA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/cdua_pkg.sv =====
package cdua_pkg;

  // word widths and queue depth
  localparam int WORD_W = 64;
  localparam int CFG_W = 32;
  localparam int PADDR_W = 4;
  localparam int QUEUE_DEPTH = 2;

  // parameter defaults
  localparam int DEF_FRAC_BITS = 16;
  localparam int DEF_DATA_WIDTH = 32;

  // saturation limits
  localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  // register map, index is paddr[3:2]
  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_BETA = 2'd1;
  localparam logic [1:0] REG_RATIO = 2'd2;

  // mode register codes
  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_ZS = 2'd1;
  localparam logic [1:0] MODE_PARALLEL = 2'd2;

  localparam logic [CFG_W-1:0] RATIO_RESET = 32'h0001_0000;

  // how the back end treats one row
  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_ZS,
    KIND_PARALLEL
  } kind_t;

  // one classified row in the queue
  typedef struct packed {
    logic first;
    logic last;
    kind_t kind;
    logic signed [WORD_W-1:0] y;
    logic signed [WORD_W-1:0] xb;
    logic signed [WORD_W-1:0] w;
    logic signed [WORD_W-1:0] xk;
    logic signed [WORD_W-1:0] xs;
    logic signed [WORD_W-1:0] a_off;
    logic signed [WORD_W-1:0] b_off;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] beta;
    logic signed [CFG_W-1:0] ratio;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic signed [WORD_W-1:0] a;
    logic signed [WORD_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic done;
    logic sat;
    logic signed [WORD_W-1:0] value;
  } mul_rsp_t;

  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_RUN,
    MUL_FIN,
    MUL_DONE
  } mul_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ISSUE,
    B_WAIT,
    B_RESID,
    B_FINAL
  } back_state_t;

  // product in flight on the shared multiplier
  typedef enum logic [2:0] {
    MOP_XR,
    MOP_BD,
    MOP_WD,
    MOP_AD,
    MOP_BR
  } mop_t;

  typedef struct packed {
    logic sat;
    logic signed [WORD_W-1:0] value;
  } arith_t;

  // saturating add
  function automatic arith_t sat_add(input logic signed [WORD_W-1:0] a,
                                     input logic signed [WORD_W-1:0] b);
    logic [WORD_W:0] s;
    arith_t r;
    s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    if (s[WORD_W] != s[WORD_W-1]) begin
      r.sat = 1'b1;
      r.value = s[WORD_W] ? WORD_MIN : WORD_MAX;
    end else begin
      r.sat = 1'b0;
      r.value = s[WORD_W-1:0];
    end
    return r;
  endfunction

  // saturating subtract
  function automatic arith_t sat_sub(input logic signed [WORD_W-1:0] a,
                                     input logic signed [WORD_W-1:0] b);
    logic [WORD_W:0] s;
    arith_t r;
    s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
    if (s[WORD_W] != s[WORD_W-1]) begin
      r.sat = 1'b1;
      r.value = s[WORD_W] ? WORD_MIN : WORD_MAX;
    end else begin
      r.sat = 1'b0;
      r.value = s[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/coord_descent_update_accumulator_core.sv =====
// Weighted least-squares coordinate-descent accumulator. Each sample request
// carries response, predictor, weight, feature and partner feature (signed
// Q16.16) plus two 64-bit offsets taken on the first row of a run; the block
// builds the direction d and adds w*d*d and w*d*r into saturating 64-bit sums,
// and on the row marked last it returns one result with the sticky saturation
// flag. Mode, beta and pair ratio are set over the APB port (0x0, 0x4, 0x8);
// the user must write them only between runs, the block does not enforce this.
// All products share one 32x32 multiplier, four partial products per 64x64
// product. A two-entry queue lets the input side take up to two samples ahead
// of the sequencer, and the result register lets the next run start while a
// result is still stalled.
module coord_descent_update_accumulator_core #(
  parameter int FRAC_BITS = cdua_pkg::DEF_FRAC_BITS,
  parameter int DATA_WIDTH = cdua_pkg::DEF_DATA_WIDTH
) (
  input  logic clk,
  input  logic rst,
  // config port
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [cdua_pkg::PADDR_W-1:0] paddr,
  input  logic [cdua_pkg::CFG_W-1:0] pwdata,
  output logic [cdua_pkg::CFG_W-1:0] prdata,
  output logic pready,
  // sample channel
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [DATA_WIDTH-1:0] response,
  input  logic signed [DATA_WIDTH-1:0] predictor,
  input  logic signed [DATA_WIDTH-1:0] weight,
  input  logic signed [DATA_WIDTH-1:0] feature,
  input  logic signed [DATA_WIDTH-1:0] partner_feature,
  input  logic signed [cdua_pkg::WORD_W-1:0] a_offset,
  input  logic signed [cdua_pkg::WORD_W-1:0] b_offset,
  input  logic last,
  // result channel
  output logic out_valid,
  input  logic out_stall,
  output logic signed [cdua_pkg::WORD_W-1:0] a_total,
  output logic signed [cdua_pkg::WORD_W-1:0] b_total,
  output logic saturated
);

  cdua_pkg::queue_stat_t qstat;
  cdua_pkg::entry_t entry;
  cdua_pkg::entry_t head;
  cdua_pkg::cfg_t cfg;
  cdua_pkg::mul_req_t mreq;
  cdua_pkg::mul_rsp_t mrsp;
  logic push;
  logic pop;

  // accept and classify
  cdua_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .response(response),
    .predictor(predictor),
    .weight(weight),
    .feature(feature),
    .partner_feature(partner_feature),
    .a_offset(a_offset),
    .b_offset(b_offset),
    .last(last),
    .qstat(qstat),
    .push(push),
    .entry(entry),
    .cfg(cfg)
  );

  // decoupling queue
  cdua_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .entry(entry),
    .pop(pop),
    .head(head),
    .qstat(qstat)
  );

  // shared multiplier
  cdua_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk(clk),
    .rst(rst),
    .req(mreq),
    .rsp(mrsp)
  );

  // sequencer and accumulators
  cdua_back u_back (
    .clk(clk),
    .rst(rst),
    .head(head),
    .qstat(qstat),
    .pop(pop),
    .cfg(cfg),
    .mreq(mreq),
    .mrsp(mrsp),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .a_total(a_total),
    .b_total(b_total),
    .saturated(saturated)
  );

endmodule

// ===== src/cdua_front.sv =====
module cdua_front #(
  parameter int DATA_WIDTH = cdua_pkg::DEF_DATA_WIDTH
) (
  input  logic clk,
  input  logic rst,
  // config port
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [cdua_pkg::PADDR_W-1:0] paddr,
  input  logic [cdua_pkg::CFG_W-1:0] pwdata,
  output logic [cdua_pkg::CFG_W-1:0] prdata,
  output logic pready,
  // sample channel
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [DATA_WIDTH-1:0] response,
  input  logic signed [DATA_WIDTH-1:0] predictor,
  input  logic signed [DATA_WIDTH-1:0] weight,
  input  logic signed [DATA_WIDTH-1:0] feature,
  input  logic signed [DATA_WIDTH-1:0] partner_feature,
  input  logic signed [cdua_pkg::WORD_W-1:0] a_offset,
  input  logic signed [cdua_pkg::WORD_W-1:0] b_offset,
  input  logic last,
  // to queue and back end
  input  cdua_pkg::queue_stat_t qstat,
  output logic push,
  output cdua_pkg::entry_t entry,
  output cdua_pkg::cfg_t cfg
);

  localparam int W = cdua_pkg::WORD_W;

  logic [1:0] mode;
  logic signed [cdua_pkg::CFG_W-1:0] beta;
  logic signed [cdua_pkg::CFG_W-1:0] ratio;
  logic run_open;
  logic wr_en;
  logic [1:0] reg_idx;

  assign reg_idx = paddr[cdua_pkg::PADDR_W-1:2];
  assign wr_en = psel & penable & pwrite;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= cdua_pkg::MODE_PLAIN;
      beta <= '0;
      ratio <= cdua_pkg::RATIO_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        cdua_pkg::REG_MODE: mode <= pwdata[1:0];
        cdua_pkg::REG_BETA: beta <= pwdata;
        cdua_pkg::REG_RATIO: ratio <= pwdata;
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_idx)
      cdua_pkg::REG_MODE: prdata = {{(cdua_pkg::CFG_W-2){1'b0}}, mode};
      cdua_pkg::REG_BETA: prdata = beta;
      cdua_pkg::REG_RATIO: prdata = ratio;
      default: prdata = '0;
    endcase
  end

  assign cfg.beta = beta;
  assign cfg.ratio = ratio;

  // accept while the queue has room
  assign in_stall = qstat.full;
  assign push = in_valid & ~qstat.full;

  // run tracking, a row after a last row opens a new run
  always_ff @(posedge clk) begin
    if (rst) begin
      run_open <= 1'b0;
    end else if (push) begin
      run_open <= ~last;
    end
  end

  // classify the row and widen its fields
  always_comb begin
    entry.first = ~run_open;
    entry.last = last;
    case (mode)
      cdua_pkg::MODE_ZS: entry.kind = cdua_pkg::KIND_ZS;
      cdua_pkg::MODE_PARALLEL: entry.kind = cdua_pkg::KIND_PARALLEL;
      default: entry.kind = cdua_pkg::KIND_PLAIN;
    endcase
    entry.y = W'(response);
    entry.xb = W'(predictor);
    entry.w = W'(weight);
    entry.xk = W'(feature);
    entry.xs = W'(partner_feature);
    entry.a_off = a_offset;
    entry.b_off = b_offset;
  end

endmodule

// ===== src/cdua_queue.sv =====
`include "coord_descent_update_accumulator_core_defines.svh"

module cdua_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cdua_pkg::entry_t entry,
  input  logic pop,
  output cdua_pkg::entry_t head,
  output cdua_pkg::queue_stat_t qstat
);

  localparam int DEPTH = cdua_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cdua_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign qstat.empty = (count == '0);
  assign qstat.full = (count == CNT_W'(DEPTH));
  assign head = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  `CDUA_ASSERT_IMPL(a_pop_nonempty, pop, count != '0, "queue popped while empty")
  `CDUA_ASSERT_NEXT(a_push_fills, push && !pop, count != '0, "queue lost a pushed request")

endmodule

// ===== src/cdua_mul.sv =====
`include "coord_descent_update_accumulator_core_defines.svh"

module cdua_mul #(
  parameter int FRAC_BITS = cdua_pkg::DEF_FRAC_BITS
) (
  input  logic clk,
  input  logic rst,
  input  cdua_pkg::mul_req_t req,
  output cdua_pkg::mul_rsp_t rsp
);

  localparam int W = cdua_pkg::WORD_W;
  localparam int H = W / 2;

  cdua_pkg::mul_state_t state;
  cdua_pkg::mul_state_t state_next;
  logic [W-1:0] ua;
  logic [W-1:0] ub;
  logic neg;
  logic [2*W-1:0] acc;
  logic [1:0] step;
  logic signed [W-1:0] value;
  logic sat;

  logic [H-1:0] a_half;
  logic [H-1:0] b_half;
  logic [W-1:0] pp;
  logic [1:0] sh;
  logic [2*W-1:0] pp_shift;

  logic hi_over;
  logic [W-1:0] m;
  logic frac;
  logic signed [W-1:0] fin_value;
  logic fin_sat;

  // next state
  always_comb begin
    case (state)
      cdua_pkg::MUL_IDLE: state_next = req.start ? cdua_pkg::MUL_RUN : cdua_pkg::MUL_IDLE;
      cdua_pkg::MUL_RUN: state_next = (step == 2'd3) ? cdua_pkg::MUL_FIN : cdua_pkg::MUL_RUN;
      cdua_pkg::MUL_FIN: state_next = cdua_pkg::MUL_DONE;
      default: state_next = cdua_pkg::MUL_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rsp.done = (state == cdua_pkg::MUL_DONE);
    rsp.sat = sat;
    rsp.value = value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdua_pkg::MUL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // one 32x32 partial product per cycle
  always_comb begin
    a_half = step[1] ? ua[W-1:H] : ua[H-1:0];
    b_half = step[0] ? ub[W-1:H] : ub[H-1:0];
    pp = a_half * b_half;
    sh = {1'b0, step[1]} + {1'b0, step[0]};
    case (sh)
      2'd0: pp_shift = {{W{1'b0}}, pp};
      2'd1: pp_shift = {{H{1'b0}}, pp, {H{1'b0}}};
      default: pp_shift = {pp, {W{1'b0}}};
    endcase
  end

  // floor shift by FRAC_BITS and saturate to a word
  always_comb begin
    hi_over = |acc[2*W-1:W+FRAC_BITS];
    m = acc[W+FRAC_BITS-1:FRAC_BITS];
    frac = |acc[FRAC_BITS-1:0];
    fin_sat = 1'b0;
    if (hi_over) begin
      fin_sat = 1'b1;
      fin_value = neg ? cdua_pkg::WORD_MIN : cdua_pkg::WORD_MAX;
    end else if (neg) begin
      if (m[W-1] && ((|m[W-2:0]) || frac)) begin
        fin_sat = 1'b1;
        fin_value = cdua_pkg::WORD_MIN;
      end else begin
        // -(m + 1) is ~m
        fin_value = frac ? ~m : ~m + 1'b1;
      end
    end else if (m[W-1]) begin
      fin_sat = 1'b1;
      fin_value = cdua_pkg::WORD_MAX;
    end else begin
      fin_value = m;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      cdua_pkg::MUL_IDLE: begin
        if (req.start) begin
          ua <= req.a[W-1] ? ~req.a + 1'b1 : req.a;
          ub <= req.b[W-1] ? ~req.b + 1'b1 : req.b;
          neg <= req.a[W-1] ^ req.b[W-1];
          acc <= '0;
          step <= '0;
        end
      end
      cdua_pkg::MUL_RUN: begin
        acc <= acc + pp_shift;
        step <= step + 1'b1;
      end
      cdua_pkg::MUL_FIN: begin
        value <= fin_value;
        sat <= fin_sat;
      end
      default: ;
    endcase
  end

  `CDUA_ASSERT_IMPL(a_start_idle, req.start, state == cdua_pkg::MUL_IDLE, "multiply started while busy")
  `CDUA_ASSERT_NEXT(a_done_pulse, rsp.done, !rsp.done, "multiply done held over one cycle")

endmodule

// ===== src/cdua_back.sv =====
`include "coord_descent_update_accumulator_core_defines.svh"

module cdua_back (
  input  logic clk,
  input  logic rst,
  // queue side
  input  cdua_pkg::entry_t head,
  input  cdua_pkg::queue_stat_t qstat,
  output logic pop,
  input  cdua_pkg::cfg_t cfg,
  // shared multiplier
  output cdua_pkg::mul_req_t mreq,
  input  cdua_pkg::mul_rsp_t mrsp,
  // result channel
  output logic out_valid,
  input  logic out_stall,
  output logic signed [cdua_pkg::WORD_W-1:0] a_total,
  output logic signed [cdua_pkg::WORD_W-1:0] b_total,
  output logic saturated
);

  localparam int W = cdua_pkg::WORD_W;

  cdua_pkg::back_state_t state;
  cdua_pkg::back_state_t state_next;
  cdua_pkg::mop_t mop;
  cdua_pkg::entry_t cur;
  logic signed [W-1:0] d;
  logic signed [W-1:0] resid;
  logic signed [W-1:0] wd;
  logic signed [W-1:0] sum_a;
  logic signed [W-1:0] sum_b;
  logic signed [W-1:0] base_a;
  logic signed [W-1:0] base_b;
  logic sat_seen;

  logic out_take;
  cdua_pkg::arith_t step_res;
  cdua_pkg::arith_t resid_res;
  cdua_pkg::arith_t fin_a;
  cdua_pkg::arith_t fin_b;

  // next state
  always_comb begin
    case (state)
      cdua_pkg::B_IDLE: state_next = qstat.empty ? cdua_pkg::B_IDLE : cdua_pkg::B_ISSUE;
      cdua_pkg::B_ISSUE: state_next = cdua_pkg::B_WAIT;
      cdua_pkg::B_WAIT: begin
        if (!mrsp.done) begin
          state_next = cdua_pkg::B_WAIT;
        end else begin
          case (mop)
            cdua_pkg::MOP_BD: state_next = cdua_pkg::B_RESID;
            cdua_pkg::MOP_BR: state_next = cur.last ? cdua_pkg::B_FINAL : cdua_pkg::B_IDLE;
            default: state_next = cdua_pkg::B_ISSUE;
          endcase
        end
      end
      cdua_pkg::B_RESID: state_next = cdua_pkg::B_ISSUE;
      cdua_pkg::B_FINAL: state_next = out_take ? cdua_pkg::B_IDLE : cdua_pkg::B_FINAL;
      default: state_next = cdua_pkg::B_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop = (state == cdua_pkg::B_IDLE) && !qstat.empty;
    out_take = (state == cdua_pkg::B_FINAL) && (!out_valid || !out_stall);
    mreq.start = (state == cdua_pkg::B_ISSUE);
  end

  // multiplier operands
  always_comb begin
    case (mop)
      cdua_pkg::MOP_XR: begin
        mreq.a = cur.xs;
        mreq.b = W'(cfg.ratio);
      end
      cdua_pkg::MOP_BD: begin
        mreq.a = W'(cfg.beta);
        mreq.b = d;
      end
      cdua_pkg::MOP_WD: begin
        mreq.a = cur.w;
        mreq.b = d;
      end
      cdua_pkg::MOP_AD: begin
        mreq.a = wd;
        mreq.b = d;
      end
      default: begin
        mreq.a = wd;
        mreq.b = resid;
      end
    endcase
  end

  // saturating add or subtract after each product except w*d
  always_comb begin
    case (mop)
      cdua_pkg::MOP_XR: step_res = cdua_pkg::sat_sub(mrsp.value, cur.xk);
      cdua_pkg::MOP_BD: begin
        if (cur.kind == cdua_pkg::KIND_PLAIN) begin
          step_res = cdua_pkg::sat_sub(cur.xb, mrsp.value);
        end else begin
          step_res = cdua_pkg::sat_add(cur.xb, mrsp.value);
        end
      end
      cdua_pkg::MOP_AD: step_res = cdua_pkg::sat_add(sum_a, mrsp.value);
      cdua_pkg::MOP_BR: step_res = cdua_pkg::sat_add(sum_b, mrsp.value);
      default: step_res = '{sat: 1'b0, value: mrsp.value};
    endcase
    resid_res = cdua_pkg::sat_sub(cur.y, resid);
    fin_a = cdua_pkg::sat_add(base_a, sum_a);
    fin_b = cdua_pkg::sat_sub(base_b, sum_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdua_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      mop <= cdua_pkg::MOP_XR;
      sum_a <= '0;
      sum_b <= '0;
      base_a <= '0;
      base_b <= '0;
      sat_seen <= 1'b0;
    end else begin
      case (state)
        cdua_pkg::B_IDLE: begin
          if (pop) begin
            cur <= head;
            // first row of a run opens fresh sums
            if (head.first) begin
              base_a <= head.a_off;
              base_b <= head.b_off;
              sum_a <= '0;
              sum_b <= '0;
              sat_seen <= 1'b0;
            end
            if (head.kind == cdua_pkg::KIND_PLAIN) begin
              d <= head.xk;
              mop <= cdua_pkg::MOP_BD;
            end else begin
              mop <= cdua_pkg::MOP_XR;
            end
          end
        end
        cdua_pkg::B_WAIT: begin
          if (mrsp.done) begin
            if (mrsp.sat || step_res.sat) begin
              sat_seen <= 1'b1;
            end
            case (mop)
              cdua_pkg::MOP_XR: begin
                d <= step_res.value;
                mop <= cdua_pkg::MOP_BD;
              end
              cdua_pkg::MOP_BD: begin
                resid <= step_res.value;
                mop <= cdua_pkg::MOP_WD;
              end
              cdua_pkg::MOP_WD: begin
                wd <= step_res.value;
                mop <= cdua_pkg::MOP_AD;
              end
              cdua_pkg::MOP_AD: begin
                sum_a <= step_res.value;
                mop <= cdua_pkg::MOP_BR;
              end
              default: begin
                sum_b <= step_res.value;
              end
            endcase
          end
        end
        cdua_pkg::B_RESID: begin
          // parallel kind keeps the predictor term as residual
          if (cur.kind != cdua_pkg::KIND_PARALLEL) begin
            resid <= resid_res.value;
            if (resid_res.sat) begin
              sat_seen <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      if (cur.kind == cdua_pkg::KIND_PLAIN) begin
        a_total <= sum_a;
        b_total <= sum_b;
        saturated <= sat_seen;
      end else begin
        a_total <= fin_a.value;
        b_total <= fin_b.value;
        saturated <= sat_seen | fin_a.sat | fin_b.sat;
      end
    end
  end

  `CDUA_ASSERT_NEXT(a_run_clears, pop && head.first, sum_a == '0 && sum_b == '0 && !sat_seen, "new run did not clear sums")
  `CDUA_ASSERT_NEXT(a_result_shown, out_take, out_valid, "closing row gave no result")

endmodule
